>>> design/thc_pkg.sv
`timescale 1ns / 1ps

package thc_pkg;

   localparam int ADC_BITS       = 10;
   localparam int DEB_W          = 8;
   localparam int IDLE_W         = 11;
   localparam int CSR_DATA_W     = 11;
   localparam int CSR_ADDR_W     = 1;
   localparam int BAND_W         = 6;
   localparam int TEMP_W         = 12;
   localparam int SET_W          = 10;
   localparam int NUM_BUTTONS    = 4;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 40;

   localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd100;
   localparam logic [IDLE_W-1:0] IDLE_RESET = 11'd300;
   localparam logic [BAND_W-1:0] BAND_MIN   = 6'd1;
   localparam logic [BAND_W-1:0] BAND_MAX   = 6'd50;

   // temperature: floor((n/8 + 158*33) / 33) - 158, 1/33 as 63551 / 2^21
   localparam logic signed [10:0] TEMP_CODE_OFS = 11'sd341;
   localparam logic signed [19:0] TEMP_BIAS     = 20'sd72600;
   localparam logic signed [16:0] TEMP_DIV_OFS  = 17'sd5214;
   localparam logic [15:0]        TEMP_RECIP    = 16'd63551;
   localparam logic signed [11:0] TEMP_Q_OFS    = 12'sd158;

   // setpoint: floor(y / 1023), 1/1023 as 1049602 / 2^30
   localparam logic [19:0] SET_BIAS  = 20'd306900;
   localparam logic [20:0] SET_RECIP = 21'd1049602;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_DEBOUNCE_COUNT     = 1'b0,
      REG_IDLE_FAN_THRESHOLD = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      BTN_RUN  = 2'd0,
      BTN_UP   = 2'd1,
      BTN_DOWN = 2'd2,
      BTN_VIEW = 2'd3
   } button_type;

   typedef struct packed {
      logic [SET_W-1:0]         setpoint_tenths;
      logic signed [TEMP_W-1:0] temperature_tenths;
      logic [BAND_W-1:0]        hysteresis_tenths;
      logic                     show_fan;
      logic                     running;
      logic                     alarm_on;
      logic                     fan_on;
      logic                     heater_on;
   } rsp_fields_type;

endpackage

>>> design/thermostat_hysteresis_controller_top.sv
`timescale 1ns / 1ps
// Each result is registered in the output register (or in the skid entry while rsp_ is stalled) and presented on rsp_.
// Throughput: one item per cycle while req_tready is high; conversions and control are combinational logic.
// A two-entry result buffer lets one more item in while a result is stalled.
// Reset (synchronous): registers to defaults (debounce 100, idle threshold 300,
// band 1, all flags, drives and readings zero), result buffer emptied.
module thermostat_hysteresis_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] temp_code, [19:10] setpoint_code, [20] run_button_n,
   // [21] up_button_n, [22] down_button_n, [23] view_button_n
   input  logic [thc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] new_reading
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] heater_on, [1] fan_on, [2] alarm_on, [3] running, [4] show_fan,
   // [10:5] hysteresis_tenths, [22:11] temperature_tenths,
   // [32:23] setpoint_tenths, [39:33] zero
   output logic [thc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [thc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [thc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [thc_pkg::DEB_W-1:0]         deb_count_ff;
   logic [thc_pkg::IDLE_W-1:0]        idle_thr_ff;

   logic                              run_ff, run_in;
   logic                              view_ff, view_in;
   logic [thc_pkg::BAND_W-1:0]        band_ff, band_in;
   logic signed [thc_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic [thc_pkg::SET_W-1:0]         set_ff, set_in;
   logic                              heater_ff, heater_in;
   logic                              fan_ff, fan_in;
   logic                              alarm_ff, alarm_in;
   logic [thc_pkg::DEB_W-1:0]         cnt_ff [thc_pkg::NUM_BUTTONS];
   logic [thc_pkg::DEB_W-1:0]         cnt_in [thc_pkg::NUM_BUTTONS];
   logic [thc_pkg::NUM_BUTTONS-1:0]   latch_ff, latch_in;
   logic [thc_pkg::NUM_BUTTONS-1:0]   fire;
   logic [thc_pkg::NUM_BUTTONS-1:0]   btn_n;

   logic                              out_valid_ff, out_valid_in;
   thc_pkg::rsp_fields_type           out_ff, out_in;
   logic                              skid_valid_ff, skid_valid_in;
   thc_pkg::rsp_fields_type           skid_ff, skid_in;
   thc_pkg::rsp_fields_type           result;

   logic                              req_fire;
   logic                              out_free;

   logic [thc_pkg::ADC_BITS-1:0]      temp_code;
   logic [thc_pkg::ADC_BITS-1:0]      set_code;
   logic signed [10:0]                tc_ofs;
   logic signed [19:0]                tc_ext;
   logic signed [19:0]                t_num;
   logic signed [16:0]                t_div8;
   logic [15:0]                       t_y;
   logic [31:0]                       t_mul;
   logic [10:0]                       t_q;
   logic signed [thc_pkg::TEMP_W-1:0] temp_conv;
   logic [19:0]                       s_num;
   logic [40:0]                       s_mul;
   logic [thc_pkg::SET_W-1:0]         set_conv;

   logic signed [12:0]                ct, cs, ch, cidle;
   logic signed [15:0]                ct16, cs16, t_x10, s_x12;

   assign temp_code = req_tdata[9:0];
   assign set_code  = req_tdata[19:10];
   assign btn_n     = req_tdata[23:20];

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // reading conversion
   always_comb begin
      tc_ofs    = $signed({1'b0, temp_code}) - thc_pkg::TEMP_CODE_OFS;
      tc_ext    = 20'(tc_ofs);
      t_num     = (tc_ext <<< 8) + (tc_ext <<< 6) + (tc_ext <<< 4) - tc_ext
                  + thc_pkg::TEMP_BIAS;
      t_div8    = t_num[19:3];
      t_y       = 16'(t_div8 + thc_pkg::TEMP_DIV_OFS);
      t_mul     = 32'(t_y) * 32'(thc_pkg::TEMP_RECIP);
      t_q       = t_mul[31:21];
      temp_conv = $signed({1'b0, t_q}) - thc_pkg::TEMP_Q_OFS;

      s_num     = ({1'b0, set_code, 9'b0} - {7'b0, set_code, 3'b0}
                  - {8'b0, set_code, 2'b0}) + thc_pkg::SET_BIAS;
      s_mul     = 41'(s_num) * 41'(thc_pkg::SET_RECIP);
      set_conv  = s_mul[39:30];
   end

   // control stage on stored readings, then conversion, then buttons
   always_comb begin
      ct    = 13'(temp_ff);
      cs    = $signed({3'b0, set_ff});
      ch    = $signed({7'b0, band_ff});
      cidle = $signed({2'b0, idle_thr_ff});
      ct16  = 16'(ct);
      cs16  = 16'(cs);
      t_x10 = (ct16 <<< 3) + (ct16 <<< 1);
      s_x12 = (cs16 <<< 3) + (cs16 <<< 2);

      heater_in = heater_ff;
      fan_in    = fan_ff;
      alarm_in  = alarm_ff;
      if (run_ff) begin
         if (ct < cs - ch) begin
            fan_in    = 1'b0;
            heater_in = 1'b1;
         end else if (ct > cs + ch) begin
            heater_in = 1'b0;
         end
         if (t_x10 > s_x12) begin
            fan_in   = 1'b1;
            alarm_in = 1'b1;
         end
         if (ct <= cs) begin
            fan_in   = 1'b0;
            alarm_in = 1'b0;
         end
      end else begin
         heater_in = 1'b0;
         alarm_in  = 1'b0;
         fan_in    = (ct > cidle);
      end

      temp_in = temp_ff;
      set_in  = set_ff;
      if (req_tuser) begin
         temp_in = temp_conv;
         set_in  = set_conv;
      end

      for (int i = 0; i < thc_pkg::NUM_BUTTONS; i++) begin
         cnt_in[i]   = cnt_ff[i];
         latch_in[i] = latch_ff[i];
         fire[i]     = 1'b0;
         if (!btn_n[i]) begin
            if (!latch_ff[i]) begin
               cnt_in[i] = cnt_ff[i] - 8'd1;
               if (cnt_in[i] == '0) begin
                  latch_in[i] = 1'b1;
                  fire[i]     = 1'b1;
               end
            end
         end else begin
            cnt_in[i]   = deb_count_ff;
            latch_in[i] = 1'b0;
         end
      end

      run_in  = run_ff ^ fire[thc_pkg::BTN_RUN];
      view_in = view_ff ^ fire[thc_pkg::BTN_VIEW];
      band_in = band_ff;
      if (fire[thc_pkg::BTN_UP]) begin
         band_in = (band_in >= thc_pkg::BAND_MAX) ? thc_pkg::BAND_MAX : band_in + 6'd1;
      end
      if (fire[thc_pkg::BTN_DOWN]) begin
         band_in = (band_in <= thc_pkg::BAND_MIN) ? thc_pkg::BAND_MIN : band_in - 6'd1;
      end

      result.heater_on          = heater_in;
      result.fan_on             = fan_in;
      result.alarm_on           = alarm_in;
      result.running            = run_in;
      result.show_fan           = view_in;
      result.hysteresis_tenths  = band_in;
      result.temperature_tenths = temp_in;
      result.setpoint_tenths    = set_in;
   end

   // result buffer: output register plus one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (req_fire) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_count_ff <= thc_pkg::DEB_RESET;
         idle_thr_ff  <= thc_pkg::IDLE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            thc_pkg::REG_DEBOUNCE_COUNT: begin
               deb_count_ff <= csr_wdata[thc_pkg::DEB_W-1:0];
            end
            thc_pkg::REG_IDLE_FAN_THRESHOLD: begin
               idle_thr_ff <= csr_wdata[thc_pkg::IDLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         view_ff   <= 1'b0;
         band_ff   <= thc_pkg::BAND_MIN;
         temp_ff   <= '0;
         set_ff    <= '0;
         heater_ff <= 1'b0;
         fan_ff    <= 1'b0;
         alarm_ff  <= 1'b0;
         latch_ff  <= '0;
         for (int i = 0; i < thc_pkg::NUM_BUTTONS; i++) begin
            cnt_ff[i] <= thc_pkg::DEB_RESET;
         end
      end else if (req_fire) begin
         run_ff    <= run_in;
         view_ff   <= view_in;
         band_ff   <= band_in;
         temp_ff   <= temp_in;
         set_ff    <= set_in;
         heater_ff <= heater_in;
         fan_ff    <= fan_in;
         alarm_ff  <= alarm_in;
         latch_ff  <= latch_in;
         for (int i = 0; i < thc_pkg::NUM_BUTTONS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff};

endmodule

>>> design/thc_checker.sv
`timescale 1ns / 1ps
module thc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [thc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   thc_pkg::rsp_fields_type rsp_f;
   assign rsp_f = rsp_tdata[$bits(thc_pkg::rsp_fields_type)-1:0];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result buffer not empty after reset");

   // input blocked only with both buffer entries full
   a_ready_buf: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req blocked with empty output");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_f.hysteresis_tenths >= thc_pkg::BAND_MIN
                  && rsp_f.hysteresis_tenths <= thc_pkg::BAND_MAX
                  && rsp_f.setpoint_tenths <= 10'd800)
      else $error("hysteresis or setpoint out of range");

endmodule

bind thermostat_hysteresis_controller_top thc_checker u_thc_checker (.*);

>>> tb/thermostat_hysteresis_controller_top_test.sv
`timescale 1ns / 1ps

module thermostat_hysteresis_controller_top_test;
   import thc_pkg::*;

   class thermostat_scoreboard;
      bit                run_flag;
      bit                view_flag;
      bit                heater;
      bit                fan;
      bit                buzzer;
      logic [BAND_W-1:0] band;
      logic signed [TEMP_W-1:0] temp_t;
      logic [SET_W-1:0]  target_t;
      logic [DEB_W-1:0]  deb_count;
      logic [IDLE_W-1:0] idle_thr;
      logic [DEB_W-1:0]  press_cnt[NUM_BUTTONS];
      bit                press_held[NUM_BUTTONS];
      rsp_fields_type    expected_status[$];
      int                fail_count;

      function new();
         run_flag  = 1'b0;
         view_flag = 1'b0;
         heater    = 1'b0;
         fan       = 1'b0;
         buzzer    = 1'b0;
         band      = BAND_MIN;
         temp_t    = '0;
         target_t  = '0;
         deb_count = DEB_RESET;
         idle_thr  = IDLE_RESET;
         fail_count = 0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_cnt[i]  = DEB_RESET;
            press_held[i] = 1'b0;
         end
      endfunction

      task report(string msg);
         $display("%0t ERROR: %s", $realtime, msg);
         fail_count++;
      endtask

      function int to_temperature(int code);
         int num;
         num = (code - 341) * 335 + 72600;
         if (num >= 0) return num / 264;
         return -((-num + 263) / 264);
      endfunction

      function int to_setpoint(int code);
         return (500 * code + 306900) / 1023;
      endfunction

      function void write_reg(csr_reg_type r, logic [CSR_DATA_W-1:0] value);
         case (r)
            REG_DEBOUNCE_COUNT:     deb_count = value[DEB_W-1:0];
            REG_IDLE_FAN_THRESHOLD: idle_thr  = value[IDLE_W-1:0];
            default: ;
         endcase
      endfunction

      function bit button_fires(button_type b, bit level_n);
         if (!level_n) begin
            if (!press_held[b]) begin
               press_cnt[b] = press_cnt[b] - 8'd1;
               if (press_cnt[b] == 0) begin
                  press_held[b] = 1'b1;
                  return 1'b1;
               end
            end
         end else begin
            press_cnt[b]  = deb_count;
            press_held[b] = 1'b0;
         end
         return 1'b0;
      endfunction

      function void note_sample(bit fresh, int tc, int sc, logic [3:0] btn_n);
         int t;
         int s;
         int h;
         int idle;
         rsp_fields_type e;
         t    = temp_t;
         s    = target_t;
         h    = band;
         idle = idle_thr;
         // control acts on readings stored by earlier items
         if (run_flag) begin
            if (t < s - h) begin
               fan    = 1'b0;
               heater = 1'b1;
            end else if (t > s + h) begin
               heater = 1'b0;
            end
            if (10 * t > 12 * s) begin
               fan    = 1'b1;
               buzzer = 1'b1;
            end
            if (t <= s) begin
               fan    = 1'b0;
               buzzer = 1'b0;
            end
         end else begin
            heater = 1'b0;
            buzzer = 1'b0;
            fan    = (t > idle);
         end
         if (fresh) begin
            temp_t   = to_temperature(tc);
            target_t = to_setpoint(sc);
         end
         if (button_fires(BTN_RUN, btn_n[0])) run_flag = !run_flag;
         if (button_fires(BTN_UP, btn_n[1])) band = (band >= BAND_MAX) ? BAND_MAX : band + 1;
         if (button_fires(BTN_DOWN, btn_n[2])) band = (band <= BAND_MIN) ? BAND_MIN : band - 1;
         if (button_fires(BTN_VIEW, btn_n[3])) view_flag = !view_flag;
         e.heater_on          = heater;
         e.fan_on             = fan;
         e.alarm_on           = buzzer;
         e.running            = run_flag;
         e.show_fan           = view_flag;
         e.hysteresis_tenths  = band;
         e.temperature_tenths = temp_t;
         e.setpoint_tenths    = target_t;
         expected_status.push_back(e);
      endfunction

      task compare_field(string name, logic [11:0] got, logic [11:0] want);
         if (got !== want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
      endtask

      task check_status(logic [RSP_DATA_W-1:0] data);
         rsp_fields_type got;
         rsp_fields_type e;
         got = data[$bits(rsp_fields_type)-1:0];
         if (data[RSP_DATA_W-1:$bits(rsp_fields_type)] !== '0) begin
            report($sformatf("padding bits not zero: 0x%0h", data));
         end
         if (expected_status.size() == 0) begin
            report($sformatf("status item with no sample pending: 0x%0h", data));
            return;
         end
         e = expected_status.pop_front();
         compare_field("heater_on", got.heater_on, e.heater_on);
         compare_field("fan_on", got.fan_on, e.fan_on);
         compare_field("alarm_on", got.alarm_on, e.alarm_on);
         compare_field("running", got.running, e.running);
         compare_field("show_fan", got.show_fan, e.show_fan);
         compare_field("hysteresis_tenths", got.hysteresis_tenths, e.hysteresis_tenths);
         compare_field("temperature_tenths", got.temperature_tenths, e.temperature_tenths);
         compare_field("setpoint_tenths", got.setpoint_tenths, e.setpoint_tenths);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   thermostat_scoreboard sb = new();
   bit         quiet = 1'b0;
   int         hold_asks = 0;
   logic [3:0] btn_level = 4'hF;
   int         btn_left[NUM_BUTTONS] = '{default: 0};

   thermostat_hysteresis_controller_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(bit fresh, int tc, int sc, logic [3:0] btn_n);
      if (!quiet && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fresh;
      req_tdata  <= {btn_n, 10'(sc), 10'(tc)};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(fresh, tc, sc, btn_n);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] deb, logic [CSR_DATA_W-1:0] idle);
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_DEBOUNCE_COUNT;
      csr_wdata <= deb;
      @(posedge clock);
      sb.write_reg(REG_DEBOUNCE_COUNT, deb);
      csr_addr  <= REG_IDLE_FAN_THRESHOLD;
      csr_wdata <= idle;
      @(posedge clock);
      sb.write_reg(REG_IDLE_FAN_THRESHOLD, idle);
      csr_we <= 1'b0;
   endtask

   // bias 1 favors hysteresis up presses, bias 2 favors down presses
   task automatic run_phase(int count, int bias);
      int tc;
      int sc;
      int tgt;
      int s;
      int h;
      int eff;
      bit fresh;
      for (int n = 0; n < count; n++) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (btn_left[b] == 0) begin
               btn_level[b] = ~btn_level[b];
               if (!btn_level[b]) begin
                  eff = (sb.deb_count == 0) ? 256 : sb.deb_count;
                  btn_left[b] = $urandom_range(0, 1) ? $urandom_range(eff, eff + 4)
                                                     : $urandom_range(1, eff);
               end else if ((bias == 1 && b == BTN_DOWN) || (bias == 2 && b == BTN_UP)) begin
                  btn_left[b] = $urandom_range(20, 80);
               end else begin
                  btn_left[b] = $urandom_range(1, 8);
               end
            end
            btn_left[b]--;
         end
         fresh = ($urandom_range(0, 99) < 70);
         if ($urandom_range(0, 9) == 0) sc = $urandom_range(0, 1) ? 1023 : 0;
         else sc = $urandom_range(0, 1023);
         s = sb.to_setpoint(sc);
         h = sb.band;
         case ($urandom_range(0, 4))
            0: tc = $urandom_range(0, 1023);
            1: tc = $urandom_range(0, 1) ? 1023 : 0;
            default: begin
               // aim the temperature at a control boundary
               case ($urandom_range(0, 3))
                  0: tgt = s - h;
                  1: tgt = s + h;
                  2: tgt = (12 * s) / 10;
                  default: tgt = s;
               endcase
               tgt += int'($urandom_range(0, 4)) - 2;
               tc = 341 + (tgt * 264 - 72600) / 335 + int'($urandom_range(0, 2)) - 1;
               if (tc < 0) tc = 0;
               if (tc > 1023) tc = 1023;
            end
         endcase
         send_item(fresh, tc, sc, btn_level);
      end
   endtask

   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 32);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("thermostat_hysteresis_controller_top_test: FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      run_phase(150, 0);
      wait_drained();

      // directed: code extremes, ignored codes, each button, simultaneous presses
      configure(1, 0);
      send_item(1, 0, 0, 4'hF);
      send_item(1, 1023, 1023, 4'hF);
      send_item(0, 1023, 0, 4'hF);
      send_item(1, 341, 512, 4'hF);
      send_item(1, 512, 0, 4'hE);
      send_item(1, 900, 0, 4'hE);
      send_item(1, 900, 0, 4'hF);
      send_item(1, 900, 0, 4'hF);
      send_item(1, 200, 1023, 4'h9);
      send_item(1, 200, 1023, 4'hF);
      send_item(1, 400, 300, 4'h7);
      send_item(1, 400, 300, 4'hF);
      send_item(1, 1023, 0, 4'h0);
      send_item(0, 0, 0, 4'hF);
      send_item(0, 0, 0, 4'hF);
      send_item(1, 600, 700, 4'hD);
      send_item(1, 600, 700, 4'hF);
      send_item(1, 0, 1023, 4'hB);
      send_item(0, 0, 0, 4'hF);
      wait_drained();

      quiet <= 1'b1;
      run_phase(200, 1);
      wait_drained();
      quiet <= 1'b0;

      configure(3, 1200);
      run_phase(200, 2);
      wait_drained();

      // zero count: a press needs 256 samples
      configure(0, 600);
      run_phase(300, 0);
      wait_drained();

      configure(11'h7FF, $urandom_range(0, 1200));
      run_phase(150, 0);
      wait_drained();

      configure(2, $urandom_range(0, 1200));
      run_phase(150, 0);
      hold_asks <= hold_asks + 1;
      run_phase(200, 0);
      wait_drained();

      repeat (4) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("thermostat_hysteresis_controller_top_test: PASS");
      end else begin
         $display("thermostat_hysteresis_controller_top_test: FAIL");
      end
      $finish;
   end

endmodule

>>> thermostat_hysteresis_controller_top.f
design/thc_pkg.sv
design/thermostat_hysteresis_controller_top.sv
design/thc_checker.sv
tb/thermostat_hysteresis_controller_top_test.sv
